// ===== rtl/pf_pkg.sv =====
// Shared types, constants and helper functions for the Playfair cipher core.
// Used by the controller, datapath and top level; depends on nothing.
package pf_pkg;

  localparam int unsigned AlphaSize = 26;
  localparam int unsigned SqSide    = 5;
  localparam int unsigned SqCells   = SqSide * SqSide;

  typedef logic [4:0] pf_letter_t;
  typedef logic [4:0] pf_cell_t;
  typedef logic [2:0] pf_coord_t;

  localparam pf_letter_t LetterI    = 5'd8;
  localparam pf_letter_t LetterJ    = 5'd9;
  localparam pf_letter_t LetterX    = 5'd23;
  localparam pf_letter_t LetterLast = 5'(AlphaSize - 1);
  localparam logic [6:0] AsciiUpperA = 7'h41;

  typedef enum logic [2:0] {
    OP_NEW_KEY  = 3'd0,
    OP_KEY_BYTE = 3'd1,
    OP_END_KEY  = 3'd2,
    OP_MSG_BYTE = 3'd3,
    OP_END_MSG  = 3'd4
  } pf_op_e;

  typedef enum logic [1:0] {
    EMIT_HELD,
    EMIT_A,
    EMIT_B,
    EMIT_END
  } pf_emit_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FILL,
    ST_MSG,
    ST_LOOKUP,
    ST_SQUARE,
    ST_EMIT_HELD,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_EMIT_END
  } pf_state_e;

  typedef struct packed {
    logic     in_ready;
    logic     clr_square;
    logic     clr_msg;
    logic     place_key;
    logic     fill_start;
    logic     fill_step;
    logic     set_complete;
    logic     msg_step;
    logic     end_pair;
    logic     emit;
    pf_emit_e emit_sel;
    logic     set_held;
  } pf_cmd_t;

  typedef struct packed {
    logic       in_fire;
    logic [2:0] op;
    logic       is_letter;
    logic       complete;
    logic       encrypt;
    logic       pend_valid;
    logic       needs_pair;
    logic       held_valid;
    logic       walk_last;
    logic       out_free;
  } pf_sts_t;

  typedef struct packed {
    logic       is_letter;
    pf_letter_t letter;
  } pf_clean_t;

  // Case-folds an ASCII byte to a letter index and folds J onto I.
  function automatic pf_clean_t pf_clean(input logic [7:0] b);
    pf_clean_t r;
    r.is_letter = 1'b0;
    r.letter    = '0;
    if (b >= 8'h61 && b <= 8'h7a) begin
      r.is_letter = 1'b1;
      r.letter    = 5'(b - 8'h61);
    end else if (b >= 8'h41 && b <= 8'h5a) begin
      r.is_letter = 1'b1;
      r.letter    = 5'(b - 8'h41);
    end
    if (r.letter == LetterJ) begin
      r.letter = LetterI;
    end
    return r;
  endfunction

  function automatic pf_coord_t pf_row(input pf_cell_t c);
    pf_coord_t r;
    r = '0;
    for (int i = 1; i < SqSide; i++) begin
      if (c >= 5'(i * SqSide)) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  function automatic pf_cell_t pf_addr(input pf_coord_t r, input pf_coord_t k);
    return 5'(5'(r) * 5'(SqSide) + 5'(k));
  endfunction

  function automatic pf_coord_t pf_col(input pf_cell_t c);
    return 3'(c - pf_addr(pf_row(c), 3'd0));
  endfunction

  // Moves one place along a row or column with wrap-around.
  function automatic pf_coord_t pf_shift(input pf_coord_t x, input logic enc);
    pf_coord_t r;
    if (enc) begin
      r = (x == 3'(SqSide - 1)) ? 3'd0 : 3'(x + 3'd1);
    end else begin
      r = (x == 3'd0) ? 3'(SqSide - 1) : 3'(x - 3'd1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/pf_in_if.sv =====
// Input channel of the Playfair cipher core: opcode and byte with valid/ready.
// Standalone; no package needed.
interface pf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] byte_in;

  modport source (output valid, output opcode, output byte_in, input ready);
  modport sink   (input valid, input opcode, input byte_in, output ready);
endinterface

// ===== rtl/pf_out_if.sv =====
// Output channel of the Playfair cipher core: result letter and flags with valid/ready.
// Standalone; no package needed.
interface pf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] letter_out;
  logic       last_of_message;
  logic       no_letter;
  logic       odd_length_error;

  modport source (output valid, output letter_out, output last_of_message,
                  output no_letter, output odd_length_error, input ready);
  modport sink   (input valid, input letter_out, input last_of_message,
                  input no_letter, input odd_length_error, output ready);
endinterface

// ===== rtl/pf_ctrl.sv =====
// Controller state machine of the Playfair cipher core.
// Depends on pf_pkg; drives the datapath through pf_cmd_t and reads pf_sts_t.
module pf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pf_pkg::pf_sts_t  sts_i,
  output pf_pkg::pf_cmd_t  cmd_o
);
  import pf_pkg::*;

  pf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.in_fire) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts_i.op)
          OP_NEW_KEY:  state_d = ST_IDLE;
          OP_KEY_BYTE: state_d = ST_IDLE;
          OP_END_KEY:  state_d = sts_i.complete ? ST_IDLE : ST_FILL;
          OP_MSG_BYTE: state_d = sts_i.complete ? ST_MSG : ST_FILL;
          OP_END_MSG: begin
            if (sts_i.complete && sts_i.encrypt && sts_i.pend_valid) begin
              state_d = ST_LOOKUP;
            end else begin
              state_d = ST_EMIT_END;
            end
          end
          default:     state_d = ST_IDLE;
        endcase
      end
      ST_FILL: begin
        if (sts_i.walk_last) begin
          state_d = (sts_i.op == OP_MSG_BYTE) ? ST_MSG : ST_IDLE;
        end
      end
      ST_MSG: begin
        state_d = (sts_i.is_letter && sts_i.needs_pair) ? ST_LOOKUP : ST_IDLE;
      end
      ST_LOOKUP: state_d = ST_SQUARE;
      ST_SQUARE: begin
        if (!sts_i.encrypt && sts_i.held_valid) begin
          state_d = ST_EMIT_HELD;
        end else begin
          state_d = ST_EMIT_A;
        end
      end
      ST_EMIT_HELD: begin
        if (sts_i.out_free) state_d = ST_EMIT_A;
      end
      ST_EMIT_A: begin
        if (sts_i.out_free) state_d = sts_i.encrypt ? ST_EMIT_B : ST_IDLE;
      end
      ST_EMIT_B: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_EMIT_END: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.emit_sel = EMIT_A;
    case (state_q)
      ST_IDLE: cmd_o.in_ready = 1'b1;
      ST_DISPATCH: begin
        case (sts_i.op)
          OP_NEW_KEY: begin
            cmd_o.clr_square = 1'b1;
            cmd_o.clr_msg    = 1'b1;
          end
          OP_KEY_BYTE: cmd_o.place_key  = !sts_i.complete;
          OP_END_KEY:  cmd_o.fill_start = !sts_i.complete;
          OP_MSG_BYTE: cmd_o.fill_start = !sts_i.complete;
          OP_END_MSG: begin
            cmd_o.end_pair = sts_i.complete && sts_i.encrypt && sts_i.pend_valid;
          end
          default: ;
        endcase
      end
      ST_FILL: begin
        cmd_o.fill_step    = 1'b1;
        cmd_o.set_complete = sts_i.walk_last;
      end
      ST_MSG: cmd_o.msg_step = sts_i.is_letter;
      ST_EMIT_HELD: begin
        cmd_o.emit     = sts_i.out_free;
        cmd_o.emit_sel = EMIT_HELD;
      end
      ST_EMIT_A: begin
        cmd_o.emit     = sts_i.out_free;
        cmd_o.emit_sel = EMIT_A;
        cmd_o.set_held = sts_i.out_free && !sts_i.encrypt;
      end
      ST_EMIT_B: begin
        cmd_o.emit     = sts_i.out_free;
        cmd_o.emit_sel = EMIT_B;
        cmd_o.clr_msg  = sts_i.out_free && (sts_i.op == OP_END_MSG);
      end
      ST_EMIT_END: begin
        cmd_o.emit     = sts_i.out_free;
        cmd_o.emit_sel = EMIT_END;
        cmd_o.clr_msg  = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/pf_dp.sv =====
// Datapath of the Playfair cipher core: key square memories, message state,
// pair lookup and output register. Depends on pf_pkg, pf_in_if and pf_out_if.
module pf_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  pf_in_if.sink           in_i,
  pf_out_if.source        out_o,
  input  pf_pkg::pf_cmd_t cmd_i,
  output pf_pkg::pf_sts_t sts_o
);
  import pf_pkg::*;

  logic                 in_fire;
  pf_clean_t            clean_in;
  logic [2:0]           op_q;
  logic                 is_letter_q;
  pf_letter_t           letter_q;
  logic                 mode_q;
  logic [AlphaSize-1:0] used_q;
  pf_cell_t             fill_q;
  logic                 complete_q;
  pf_letter_t           walk_q;
  logic                 prev_valid_q, pend_valid_q, held_valid_q;
  pf_letter_t           prev_q, pend_q, held_q;
  pf_letter_t           pa_q, pb_q;
  pf_cell_t             ca_q, cb_q;
  pf_letter_t           oa_q, ob_q;
  logic                 out_valid_q;
  logic [6:0]           out_letter_q;
  logic                 out_last_q, out_nol_q, out_err_q;

  pf_cell_t             cell_mem [AlphaSize];
  pf_letter_t           square_mem [SqCells];

  pf_letter_t           place_l;
  logic                 place_ok, place_we;
  logic                 dup, needs_pair, pend_valid_d;
  pf_letter_t           pa_d, pb_d;
  pf_coord_t            ra, ka, rb, kb;
  pf_cell_t             addr_a, addr_b;
  logic                 out_free;
  pf_letter_t           emit_l;
  logic                 emit_last, emit_nol, emit_err;

  assign in_i.ready = cmd_i.in_ready;
  assign in_fire    = in_i.valid & in_i.ready;
  assign clean_in   = pf_clean(in_i.byte_in);

  always_comb begin
    if (cmd_i.fill_step) begin
      place_l  = walk_q;
      place_ok = (walk_q != LetterJ);
    end else begin
      place_l  = letter_q;
      place_ok = cmd_i.place_key & is_letter_q;
    end
    place_we = place_ok && !used_q[place_l] && (fill_q < 5'(SqCells));
  end

  assign dup        = prev_valid_q && (prev_q == letter_q);
  assign needs_pair = mode_q ? (pend_valid_q | dup) : pend_valid_q;

  always_comb begin
    if (cmd_i.end_pair) begin
      pa_d         = pend_q;
      pb_d         = LetterX;
      pend_valid_d = 1'b0;
    end else if (mode_q) begin
      pa_d         = pend_valid_q ? pend_q : LetterX;
      pb_d         = (dup && pend_valid_q) ? LetterX : letter_q;
      pend_valid_d = ~(dup ^ pend_valid_q);
    end else begin
      pa_d         = pend_q;
      pb_d         = letter_q;
      pend_valid_d = ~pend_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q         <= '0;
      mode_q       <= 1'b1;
      used_q       <= '0;
      fill_q       <= '0;
      complete_q   <= 1'b0;
      walk_q       <= '0;
      prev_valid_q <= 1'b0;
      pend_valid_q <= 1'b0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        op_q <= in_i.opcode;
      end
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_square) begin
        used_q     <= '0;
        fill_q     <= '0;
        complete_q <= 1'b0;
      end else begin
        if (place_we) begin
          used_q[place_l] <= 1'b1;
          fill_q          <= 5'(fill_q + 5'd1);
        end
        if (cmd_i.set_complete) begin
          complete_q <= 1'b1;
        end
      end
      if (cmd_i.fill_start) begin
        walk_q <= '0;
      end else if (cmd_i.fill_step) begin
        walk_q <= 5'(walk_q + 5'd1);
      end
      if (cfg_we_i || cmd_i.clr_msg) begin
        prev_valid_q <= 1'b0;
        pend_valid_q <= 1'b0;
        held_valid_q <= 1'b0;
      end else begin
        if (cmd_i.msg_step || cmd_i.end_pair) begin
          pend_valid_q <= pend_valid_d;
        end
        if (cmd_i.msg_step && mode_q) begin
          prev_valid_q <= 1'b1;
        end
        if (cmd_i.set_held) begin
          held_valid_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      is_letter_q <= clean_in.is_letter;
      letter_q    <= clean_in.letter;
    end
    if (cmd_i.msg_step) begin
      pend_q <= letter_q;
      prev_q <= letter_q;
    end
    if (cmd_i.msg_step || cmd_i.end_pair) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (cmd_i.set_held) begin
      held_q <= ob_q;
    end
    if (cmd_i.emit) begin
      out_letter_q <= emit_nol ? 7'd0 : 7'(AsciiUpperA + 7'(emit_l));
      out_last_q   <= emit_last;
      out_nol_q    <= emit_nol;
      out_err_q    <= emit_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (place_we) begin
      cell_mem[place_l] <= fill_q;
    end
    ca_q <= cell_mem[pa_q];
    cb_q <= cell_mem[pb_q];
  end

  always_comb begin
    ra = pf_row(ca_q);
    ka = pf_col(ca_q);
    rb = pf_row(cb_q);
    kb = pf_col(cb_q);
    if (ra == rb) begin
      addr_a = pf_addr(ra, pf_shift(ka, mode_q));
      addr_b = pf_addr(rb, pf_shift(kb, mode_q));
    end else if (ka == kb) begin
      addr_a = pf_addr(pf_shift(ra, mode_q), ka);
      addr_b = pf_addr(pf_shift(rb, mode_q), kb);
    end else begin
      addr_a = pf_addr(ra, kb);
      addr_b = pf_addr(rb, ka);
    end
  end

  always_ff @(posedge clk_i) begin
    if (place_we) begin
      square_mem[fill_q] <= place_l;
    end
    oa_q <= square_mem[addr_a];
    ob_q <= square_mem[addr_b];
  end

  always_comb begin
    emit_l    = '0;
    emit_last = 1'b0;
    emit_nol  = 1'b0;
    emit_err  = 1'b0;
    case (cmd_i.emit_sel)
      EMIT_HELD: emit_l = held_q;
      EMIT_A:    emit_l = oa_q;
      EMIT_B: begin
        emit_l    = ob_q;
        emit_last = (op_q == OP_END_MSG);
      end
      EMIT_END: begin
        emit_last = 1'b1;
        emit_nol  = 1'b1;
        if (complete_q && !mode_q) begin
          emit_err = pend_valid_q;
          if (held_valid_q && (held_q != LetterX)) begin
            emit_l   = held_q;
            emit_nol = 1'b0;
          end
        end
      end
      default: emit_nol = 1'b1;
    endcase
  end

  assign out_free               = ~out_valid_q | out_o.ready;
  assign out_o.valid            = out_valid_q;
  assign out_o.letter_out       = out_letter_q;
  assign out_o.last_of_message  = out_last_q;
  assign out_o.no_letter        = out_nol_q;
  assign out_o.odd_length_error = out_err_q;

  always_comb begin
    sts_o            = '0;
    sts_o.in_fire    = in_fire;
    sts_o.op         = op_q;
    sts_o.is_letter  = is_letter_q;
    sts_o.complete   = complete_q;
    sts_o.encrypt    = mode_q;
    sts_o.pend_valid = pend_valid_q;
    sts_o.needs_pair = needs_pair;
    sts_o.held_valid = held_valid_q;
    sts_o.walk_last  = (walk_q == LetterLast);
    sts_o.out_free   = out_free;
  end

endmodule

// ===== rtl/playfair_digraph_cipher_core.sv =====
// Top level of the Playfair cipher core: joins the controller and the datapath.
// Depends on pf_pkg, pf_in_if, pf_out_if, pf_ctrl and pf_dp.
//
// The core takes one opcode-tagged byte per input beat and works on it alone
// until its results are loaded into the output register, so the next beat can
// be taken while the last result still waits. A key byte, or a message letter
// that only waits for its partner, is just stored; a letter that completes a
// pair passes the two registered lookups (letter to cell, then cell to letter)
// and gives one result per cycle through the output register unless the output
// stalls. In decrypt mode the letter held from the previous pair goes out first.
// End of key, or the first message byte after an unfinished key, adds a walk
// over all 26 letters of the alphabet to fill the square. The encrypt_mode
// register resets to encrypt; the user must write it only while the core is
// idle, as the core does not enforce this. Writing it drops any partial message.
module playfair_digraph_cipher_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  pf_in_if.sink    in_i,
  pf_out_if.source out_o
);
  import pf_pkg::*;

  pf_cmd_t cmd;
  pf_sts_t sts;

  pf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
